// ----- rtl/vpt_pkg.sv -----
// ----------------------------------------------------------------------------
// vpt_pkg
// Shared types, constants and helpers of the vertex placement transform.
// ----------------------------------------------------------------------------
`default_nettype none

package vpt_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;

  typedef enum logic [1:0] {
    MODE_ANGLE  = 2'd0,
    MODE_SCALE  = 2'd1,
    MODE_OFFSET = 2'd2,
    MODE_VERTEX = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    SC_IDLE,
    SC_PREP,
    SC_RAD,
    SC_SQR,
    SC_R2,
    SC_TERM,
    SC_DLOAD,
    SC_DIV,
    SC_UPD,
    SC_SINM,
    SC_SINST,
    SC_FIN
  } sc_state_e;

  localparam logic [30:0]        Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0]        HALF_PI_Q30 = 31'h6487_ED51;
  localparam logic signed [31:0] SCALE_ONE   = 32'sh0001_0000;
  localparam logic signed [63:0] RND30       = 64'sd536870912;
  localparam logic signed [63:0] RND16       = 64'sd32768;
  localparam logic signed [63:0] MAX32       = 64'sd2147483647;
  localparam logic signed [63:0] MIN32       = -64'sd2147483648;
  localparam logic [3:0]         SIN_LAST    = 4'd3;
  localparam logic [3:0]         COS_LAST    = 4'd8;

  typedef struct packed {
    logic signed [31:0] sn;
    logic signed [31:0] cs;
  } vpt_trig_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               coll;
  } vpt_side_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               coll;
  } vpt_vec_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > MAX32) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < MIN32) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // reciprocals of the series divisors (72 42 20 6, then 90 56 30 12 2),
  // exact for any 30-bit dividend with the shift below
  function automatic logic [30:0] term_recip(input logic [3:0] k);
    logic [30:0] m;
    case (k)
      4'd0:    m = 31'd1908874354;
      4'd1:    m = 31'd1636178018;
      4'd2:    m = 31'd1717986919;
      4'd3:    m = 31'd1431655766;
      4'd4:    m = 31'd1527099484;
      4'd5:    m = 31'd1227133514;
      4'd6:    m = 31'd1145324613;
      4'd7:    m = 31'd1431655766;
      4'd8:    m = 31'd1073741824;
      default: m = 31'd0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] term_shift(input logic [3:0] k);
    logic [5:0] s;
    case (k)
      4'd0:    s = 6'd37;
      4'd1:    s = 6'd36;
      4'd2:    s = 6'd35;
      4'd3:    s = 6'd33;
      4'd4:    s = 6'd37;
      4'd5:    s = 6'd36;
      4'd6:    s = 6'd35;
      4'd7:    s = 6'd34;
      4'd8:    s = 6'd31;
      default: s = 6'd31;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/vpt_sincos.sv -----
// ----------------------------------------------------------------------------
// vpt_sincos
// Holds the three angles and works out their sine and cosine in Q2.30 with
// one shared multiplier; series divisions use reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module vpt_sincos
  import vpt_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [ANGLE_BITS-1:0] angle_x_i,
  input  wire logic [ANGLE_BITS-1:0] angle_y_i,
  input  wire logic [ANGLE_BITS-1:0] angle_z_i,
  output logic                       busy_o,
  output vpt_trig_t [2:0]            trig_o
);

  sc_state_e state_q, state_d;
  logic [1:0]                       axis_q;
  logic [3:0]                       k_q;
  logic [2:0][ANGLE_BITS-1:0]       angle_q;
  logic                             swap_q;
  logic [1:0]                       quad_q;
  logic [29:0]                      r_q, r2_q, dvd_q;
  logic [30:0]                      t_q, s0_q;
  logic [61:0]                      prod_q;
  vpt_trig_t [2:0]                  trig_q;

  logic [31:0] ang_w;
  logic [29:0] frac, fold;
  logic [30:0] mul_a, mul_b;
  logic [29:0] quo;
  logic signed [31:0] sv, cv;
  vpt_trig_t   fin;

  // octant fold of the widened angle
  always_comb begin
    ang_w = {angle_q[axis_q], {(32-ANGLE_BITS){1'b0}}};
    frac  = ang_w[29:0];
    fold  = frac[29] ? 30'(Q30_ONE - {1'b0, frac}) : frac;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SC_IDLE:  if (start_i) state_d = SC_PREP;
      SC_PREP:  state_d = SC_RAD;
      SC_RAD:   state_d = SC_SQR;
      SC_SQR:   state_d = SC_R2;
      SC_R2:    state_d = SC_TERM;
      SC_TERM:  state_d = SC_DLOAD;
      SC_DLOAD: state_d = SC_DIV;
      SC_DIV:   state_d = SC_UPD;
      SC_UPD: begin
        if (k_q == SIN_LAST) begin
          state_d = SC_SINM;
        end else if (k_q == COS_LAST) begin
          state_d = SC_FIN;
        end else begin
          state_d = SC_TERM;
        end
      end
      SC_SINM:  state_d = SC_SINST;
      SC_SINST: state_d = SC_TERM;
      SC_FIN:   state_d = (axis_q == 2'd2) ? SC_IDLE : SC_PREP;
      default:  state_d = SC_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != SC_IDLE);
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      SC_PREP: begin
        mul_a = {1'b0, fold};
        mul_b = HALF_PI_Q30;
      end
      SC_SQR: begin
        mul_a = {1'b0, r_q};
        mul_b = {1'b0, r_q};
      end
      SC_TERM: begin
        mul_a = {1'b0, r2_q};
        mul_b = t_q;
      end
      SC_DIV: begin
        mul_a = {1'b0, dvd_q};
        mul_b = term_recip(k_q);
      end
      SC_SINM: begin
        mul_a = {1'b0, r_q};
        mul_b = t_q;
      end
      default: ;
    endcase
  end

  // quotient of the term by its divisor
  always_comb begin
    quo = 30'(prod_q >> term_shift(k_q));
  end

  // quadrant signs and octant swap
  always_comb begin
    sv = swap_q ? {1'b0, t_q} : {1'b0, s0_q};
    cv = swap_q ? {1'b0, s0_q} : {1'b0, t_q};
    case (quad_q)
      2'd0:    begin fin.sn = sv;  fin.cs = cv;  end
      2'd1:    begin fin.sn = cv;  fin.cs = -sv; end
      2'd2:    begin fin.sn = -sv; fin.cs = -cv; end
      default: begin fin.sn = -cv; fin.cs = sv;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      axis_q  <= '0;
      k_q     <= '0;
      angle_q <= '0;
      for (int i = 0; i < 3; i++) begin
        trig_q[i].sn <= '0;
        trig_q[i].cs <= 32'(Q30_ONE);
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        SC_IDLE: begin
          if (start_i) begin
            axis_q  <= '0;
            angle_q <= {angle_z_i, angle_y_i, angle_x_i};
          end
        end
        SC_R2:    k_q   <= '0;
        SC_UPD:   k_q   <= k_q + 4'd1;
        SC_FIN: begin
          trig_q[axis_q] <= fin;
          axis_q         <= axis_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      SC_PREP: begin
        swap_q <= frac[29];
        quad_q <= ang_w[31:30];
      end
      SC_RAD: r_q <= prod_q[59:30];
      SC_R2: begin
        r2_q <= prod_q[59:30];
        t_q  <= Q30_ONE;
      end
      SC_DLOAD: dvd_q <= prod_q[59:30];
      SC_UPD: t_q <= Q30_ONE - {1'b0, quo};
      SC_SINST: begin
        s0_q <= prod_q[60:30];
        t_q  <= Q30_ONE;
      end
      default: ;
    endcase
  end

  assign trig_o = trig_q;

endmodule

`default_nettype wire

// ----- rtl/vpt_rot.sv -----
// ----------------------------------------------------------------------------
// vpt_rot
// Two-stage plane rotation of a coordinate pair: products, then rounded and
// saturated sums.
// ----------------------------------------------------------------------------
`default_nettype none

module vpt_rot
  import vpt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [1:0]         en_i,
  input  wire logic               valid_i,
  output logic [1:0]              valid_o,
  input  wire logic signed [31:0] u_i,
  input  wire logic signed [31:0] w_i,
  input  wire vpt_side_t          side_i,
  input  wire vpt_trig_t          trig_i,
  output logic signed [31:0]      u_o,
  output logic signed [31:0]      w_o,
  output vpt_side_t               side_o
);

  logic [1:0]         v_q;
  logic signed [63:0] p_uc_q, p_ws_q, p_us_q, p_wc_q;
  vpt_side_t          side0_q, side1_q;
  logic signed [31:0] u_q, w_q, u_d, w_d;
  logic signed [63:0] sum_u, sum_w;

  always_comb begin
    sum_u = p_uc_q - p_ws_q;
    sum_w = p_us_q + p_wc_q;
    u_d   = sat32((sum_u + RND30) >>> 30);
    w_d   = sat32((sum_w + RND30) >>> 30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en_i[0]) v_q[0] <= valid_i;
      if (en_i[1]) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_uc_q  <= 64'(trig_i.cs) * 64'(u_i);
      p_ws_q  <= 64'(trig_i.sn) * 64'(w_i);
      p_us_q  <= 64'(trig_i.sn) * 64'(u_i);
      p_wc_q  <= 64'(trig_i.cs) * 64'(w_i);
      side0_q <= side_i;
    end
    if (en_i[1]) begin
      u_q     <= u_d;
      w_q     <= w_d;
      side1_q <= side0_q;
    end
  end

  assign valid_o = v_q;
  assign u_o     = u_q;
  assign w_o     = w_q;
  assign side_o  = side1_q;

endmodule

`default_nettype wire

// ----- rtl/vpt_scale.sv -----
// ----------------------------------------------------------------------------
// vpt_scale
// Per-axis scale and offset in three stages; the last stage is the output
// register of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module vpt_scale
  import vpt_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [2:0]              en_i,
  input  wire logic                    valid_i,
  output logic [2:0]                   valid_o,
  input  wire vpt_vec_t                vec_i,
  input  wire logic [2:0][31:0]        scale_i,
  input  wire logic [2:0][31:0]        offset_i,
  output vpt_vec_t                     vec_o
);

  logic [2:0]                v_q;
  logic signed [2:0][63:0]   p_q;
  logic [2:0][31:0]          s_q, s_d, o_d;
  logic                      coll0_q, coll1_q;
  vpt_vec_t                  out_q;
  logic signed [32:0]        osum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_d[i]  = sat32(($signed(p_q[i]) + RND16) >>> 16);
      osum[i] = 33'($signed(s_q[i])) + 33'($signed(offset_i[i]));
      o_d[i]  = sat32(64'(osum[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en_i[0]) v_q[0] <= valid_i;
      if (en_i[1]) v_q[1] <= v_q[0];
      if (en_i[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_q[0]  <= 64'(vec_i.x) * 64'($signed(scale_i[0]));
      p_q[1]  <= 64'(vec_i.y) * 64'($signed(scale_i[1]));
      p_q[2]  <= 64'(vec_i.z) * 64'($signed(scale_i[2]));
      coll0_q <= vec_i.coll;
    end
    if (en_i[1]) begin
      s_q     <= s_d;
      coll1_q <= coll0_q;
    end
    if (en_i[2]) begin
      out_q.x    <= o_d[0];
      out_q.y    <= o_d[1];
      out_q.z    <= o_d[2];
      out_q.coll <= coll1_q;
    end
  end

  assign valid_o = v_q;
  assign vec_o   = out_q;

endmodule

`default_nettype wire

// ----- rtl/vertex_placement_transform.sv -----
// ----------------------------------------------------------------------------
// vertex_placement_transform
// Rotates vertices about x, y and z, scales and offsets them per axis.
// ----------------------------------------------------------------------------
// a vertex is registered through the x, y, z rotations, then scale and offset
// throughput: one vertex per cycle through nine pipeline stages when not stalled
// scale and offset loads wait until the pipeline holds no vertex but the output
// an angle load holds tready low while the shared multiplier works out
// three sine and cosine pairs
// reset: angles 0, scales 1.0, offsets 0, pipeline empty
`default_nettype none

module vertex_placement_transform
  import vpt_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // field_a, field_b, field_c
  input  wire logic [2:0]  s_axis_tuser,  // mode[1:0], collidable_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,  // out_x, out_y, out_z
  output logic [0:0]       m_axis_tuser   // collidable_out
);

  localparam int unsigned NS = 9;

  mode_e            mode;
  logic [NS-1:0]    v, en;
  logic             busy, pipe_empty, xfer, vin, start;
  vpt_trig_t [2:0]  trig;
  logic [2:0][31:0] scale_q, offset_q;
  vpt_vec_t         vec_in, vec_rz, vec_out;
  logic signed [31:0] y1, z1, z2, x2, x3, y3;
  vpt_side_t        sx, sy, sz, sx_o, sy_o, sz_o;

  assign mode       = mode_e'(s_axis_tuser[1:0]);
  assign pipe_empty = ~|v[NS-2:0];

  // a stage moves when it is empty or its successor moves
  always_comb begin
    en[NS-1] = !v[NS-1] || m_axis_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_comb begin
    s_axis_tready = !busy && ((mode == MODE_VERTEX) ? en[0] : pipe_empty);
    xfer          = s_axis_tvalid && s_axis_tready;
    vin           = xfer && (mode == MODE_VERTEX);
    start         = xfer && (mode == MODE_ANGLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        scale_q[i]  <= SCALE_ONE;
        offset_q[i] <= '0;
      end
    end else if (xfer && (mode == MODE_SCALE)) begin
      scale_q <= {s_axis_tdata[95:64], s_axis_tdata[63:32], s_axis_tdata[31:0]};
    end else if (xfer && (mode == MODE_OFFSET)) begin
      offset_q <= {s_axis_tdata[95:64], s_axis_tdata[63:32], s_axis_tdata[31:0]};
    end
  end

  vpt_sincos #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_sincos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .angle_x_i(s_axis_tdata[ANGLE_BITS-1:0]),
    .angle_y_i(s_axis_tdata[32+ANGLE_BITS-1:32]),
    .angle_z_i(s_axis_tdata[64+ANGLE_BITS-1:64]),
    .busy_o   (busy),
    .trig_o   (trig)
  );

  always_comb begin
    vec_in.x    = s_axis_tdata[31:0];
    vec_in.y    = s_axis_tdata[63:32];
    vec_in.z    = s_axis_tdata[95:64];
    vec_in.coll = s_axis_tuser[2];
    sx.v        = vec_in.x;
    sx.coll     = vec_in.coll;
    sy.v        = y1;
    sy.coll     = sx_o.coll;
    sz.v        = z2;
    sz.coll     = sy_o.coll;
  end

  // about x: pair (y, z)
  vpt_rot u_rot_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en[1:0]),
    .valid_i(vin),
    .valid_o(v[1:0]),
    .u_i    (vec_in.y),
    .w_i    (vec_in.z),
    .side_i (sx),
    .trig_i (trig[0]),
    .u_o    (y1),
    .w_o    (z1),
    .side_o (sx_o)
  );

  // about y: pair (z, x)
  vpt_rot u_rot_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en[3:2]),
    .valid_i(v[1]),
    .valid_o(v[3:2]),
    .u_i    (z1),
    .w_i    (sx_o.v),
    .side_i (sy),
    .trig_i (trig[1]),
    .u_o    (z2),
    .w_o    (x2),
    .side_o (sy_o)
  );

  // about z: pair (x, y)
  vpt_rot u_rot_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en[5:4]),
    .valid_i(v[3]),
    .valid_o(v[5:4]),
    .u_i    (x2),
    .w_i    (sy_o.v),
    .side_i (sz),
    .trig_i (trig[2]),
    .u_o    (x3),
    .w_o    (y3),
    .side_o (sz_o)
  );

  always_comb begin
    vec_rz.x    = x3;
    vec_rz.y    = y3;
    vec_rz.z    = sz_o.v;
    vec_rz.coll = sz_o.coll;
  end

  vpt_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[8:6]),
    .valid_i (v[5]),
    .valid_o (v[8:6]),
    .vec_i   (vec_rz),
    .scale_i (scale_q),
    .offset_i(offset_q),
    .vec_o   (vec_out)
  );

  // x and y leave exchanged
  assign m_axis_tvalid = v[NS-1];
  assign m_axis_tdata  = {vec_out.z, vec_out.x, vec_out.y};
  assign m_axis_tuser  = vec_out.coll;

endmodule

`default_nettype wire

// ----- rtl/vpt_checker.sv -----
// ----------------------------------------------------------------------------
// vpt_checker
// Port-level checks of the vertex placement transform, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module vpt_checker
  import vpt_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [95:0] s_axis_tdata,  // field_a, field_b, field_c
  input wire logic [2:0]  s_axis_tuser,  // mode[1:0], collidable_in
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [95:0] m_axis_tdata,  // out_x, out_y, out_z
  input wire logic [0:0]  m_axis_tuser   // collidable_out
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid && s_axis_tready;

  // a result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // angle load starts the trig sequencer, so input stalls next cycle
  a_angle_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser[1:0] == MODE_ANGLE) |=> !s_axis_tready)
    else $error("input taken right after angle load");

  // loads only go in with no vertex in flight ahead of the output register
  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser[1:0] != MODE_VERTEX) |=> !$rose(m_axis_tvalid))
    else $error("vertex in flight during placement load");

endmodule

bind vertex_placement_transform vpt_checker u_vpt_checker (.*);

`default_nettype wire
